### rtl/core/mrst_pkg.sv
// Shared types and constants for the MIDI receive state tracker.
package mrst_pkg;

  // Decoded event codes reported with every received byte.
  typedef enum logic [4:0] {
    EV_NONE      = 5'd0,
    EV_NOTE_ON   = 5'd1,
    EV_NOTE_OFF  = 5'd2,
    EV_POLY      = 5'd3,
    EV_CC        = 5'd4,
    EV_PROG      = 5'd5,
    EV_CHAN_PRES = 5'd6,
    EV_BEND      = 5'd7,
    EV_SONG_POS  = 5'd8,
    EV_SONG_SEL  = 5'd9,
    EV_TUNE      = 5'd10,
    EV_CLOCK     = 5'd11,
    EV_START     = 5'd12,
    EV_CONT      = 5'd13,
    EV_STOP      = 5'd14,
    EV_SENSE     = 5'd15,
    EV_RESET     = 5'd16,
    EV_SX_START  = 5'd17,
    EV_SX_DATA   = 5'd18,
    EV_SX_END    = 5'd19
  } event_kind_t;

  // Upper nibbles of channel status bytes.
  localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
  localparam logic [3:0] NIB_POLY      = 4'hA;
  localparam logic [3:0] NIB_CC        = 4'hB;
  localparam logic [3:0] NIB_PROG      = 4'hC;
  localparam logic [3:0] NIB_CHAN_PRES = 4'hD;
  localparam logic [3:0] NIB_BEND      = 4'hE;
  localparam logic [3:0] NIB_SYSTEM    = 4'hF;

  // System status bytes.
  localparam logic [7:0] SYS_SX_START = 8'hF0;
  localparam logic [7:0] SYS_SONG_POS = 8'hF2;
  localparam logic [7:0] SYS_SONG_SEL = 8'hF3;
  localparam logic [7:0] SYS_TUNE     = 8'hF6;
  localparam logic [7:0] SYS_SX_END   = 8'hF7;
  localparam logic [7:0] SYS_CLOCK    = 8'hF8;
  localparam logic [7:0] SYS_START    = 8'hFA;
  localparam logic [7:0] SYS_CONT     = 8'hFB;
  localparam logic [7:0] SYS_STOP     = 8'hFC;
  localparam logic [7:0] SYS_SENSE    = 8'hFE;
  localparam logic [7:0] SYS_RESET    = 8'hFF;

  // First controller number kept in the knob store.
  localparam int unsigned KNOB_FIRST = 21;

  // Depth of the queue between the parser and the state back end.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration register byte address.
  localparam logic [2:0] ADDR_LISTEN = 3'd0;

  // One decoded event as it travels from the parser to the back end.
  typedef struct packed {
    event_kind_t kind;
    logic [4:0]  chan;
    logic [6:0]  num;
    logic [6:0]  val;
    logic [13:0] wide;
  } event_t;

endpackage

### rtl/core/mrst_front.sv
// Byte parser: running status, system exclusive mode and channel filter.
module mrst_front
  import mrst_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic [4:0] listen_channel,
  output logic       push,
  output event_t     push_event
);

  logic       in_sysex, in_sysex_next;
  logic [7:0] running_status, running_status_next;
  logic [1:0] data_needed, data_needed_next;
  logic [1:0] data_count, data_count_next;
  logic [6:0] first_data, first_data_next;

  assign push = in_valid && !in_stall;

  // Decode the byte against the current parser state.
  always_comb begin
    logic [1:0] cnt;
    logic [4:0] ch;
    logic       pass;
    logic [6:0] last;
    event_kind_t fk;

    in_sysex_next       = in_sysex;
    running_status_next = running_status;
    data_needed_next    = data_needed;
    data_count_next     = data_count;
    first_data_next     = first_data;
    push_event.kind     = EV_NONE;
    push_event.chan     = 5'd1;
    push_event.num      = 7'd0;
    push_event.val      = 7'd0;
    push_event.wide     = 14'd0;
    cnt  = data_count + 2'd1;
    ch   = {1'b0, running_status[3:0]} + 5'd1;
    last = in_byte[6:0];
    pass = (listen_channel == 5'd0) || (ch == listen_channel) ||
           (running_status[7:4] == NIB_SYSTEM);
    fk   = EV_NONE;

    if (in_sysex && in_byte != SYS_SX_END) begin
      push_event.kind = EV_SX_DATA;
    end else if (in_byte[7]) begin
      if (in_byte[7:4] != NIB_SYSTEM) begin
        // Channel status byte opens a new message.
        running_status_next = in_byte;
        data_count_next     = 2'd0;
        if (in_byte[7:4] == NIB_PROG || in_byte[7:4] == NIB_CHAN_PRES) begin
          data_needed_next = 2'd1;
        end else begin
          data_needed_next = 2'd2;
        end
      end else begin
        unique case (in_byte)
          SYS_SONG_POS: begin
            running_status_next = in_byte;
            data_count_next     = 2'd0;
            data_needed_next    = 2'd2;
          end
          SYS_SONG_SEL: begin
            running_status_next = in_byte;
            data_count_next     = 2'd0;
            data_needed_next    = 2'd1;
          end
          SYS_SX_START: begin
            in_sysex_next   = 1'b1;
            push_event.kind = EV_SX_START;
          end
          SYS_SX_END: begin
            in_sysex_next   = 1'b0;
            push_event.kind = EV_SX_END;
          end
          SYS_TUNE:  push_event.kind = EV_TUNE;
          SYS_CLOCK: push_event.kind = EV_CLOCK;
          SYS_START: push_event.kind = EV_START;
          SYS_CONT:  push_event.kind = EV_CONT;
          SYS_STOP:  push_event.kind = EV_STOP;
          SYS_SENSE: push_event.kind = EV_SENSE;
          SYS_RESET: push_event.kind = EV_RESET;
          default:   push_event.kind = EV_NONE;
        endcase
      end
    end else if (data_needed != 2'd0) begin
      // Data byte of a pending message.
      first_data_next = in_byte[6:0];
      if (cnt == data_needed) begin
        data_count_next = 2'd0;
        unique case (running_status[7:4])
          NIB_NOTE_OFF:  fk = EV_NOTE_OFF;
          NIB_NOTE_ON:   fk = (last != 7'd0) ? EV_NOTE_ON : EV_NOTE_OFF;
          NIB_POLY:      fk = EV_POLY;
          NIB_CC:        fk = EV_CC;
          NIB_PROG:      fk = EV_PROG;
          NIB_CHAN_PRES: fk = EV_CHAN_PRES;
          NIB_BEND:      fk = EV_BEND;
          NIB_SYSTEM: begin
            if (running_status == SYS_SONG_POS) begin
              fk = EV_SONG_POS;
            end else if (running_status == SYS_SONG_SEL) begin
              fk = EV_SONG_SEL;
            end else begin
              fk = EV_NONE;
            end
          end
          default: fk = EV_NONE;
        endcase
        if (pass && fk != EV_NONE) begin
          push_event.kind = fk;
          if (running_status[7:4] != NIB_SYSTEM) begin
            push_event.chan = ch;
          end
          push_event.num = (data_needed == 2'd2) ? first_data : last;
          push_event.val = last;
          if (fk == EV_BEND || fk == EV_SONG_POS) begin
            push_event.wide = {last, first_data};
          end
        end
      end else begin
        data_count_next = cnt;
      end
    end
  end

  // Parser state advances on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_sysex       <= 1'b0;
      running_status <= 8'd0;
      data_needed    <= 2'd0;
      data_count     <= 2'd0;
      first_data     <= 7'd0;
    end else if (push) begin
      in_sysex       <= in_sysex_next;
      running_status <= running_status_next;
      data_needed    <= data_needed_next;
      data_count     <= data_count_next;
      first_data     <= first_data_next;
    end
  end

endmodule

### rtl/core/mrst_queue.sv
// Short event queue between the parser and the state back end.
module mrst_queue
  import mrst_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  event_t push_event,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output event_t head_event
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  event_t          slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     fill;

  assign full       = (fill == (PW+1)'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_event = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_event;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### rtl/core/mrst_back.sv
// Performance state (notes, knobs, program, clock) and the output register.
module mrst_back
  import mrst_pkg::*;
#(
  parameter int unsigned KNOB_COUNT      = 5,
  parameter int unsigned CLOCKS_PER_BEAT = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  event_t      head_event,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  event_kind,
  output logic [4:0]  event_channel,
  output logic [6:0]  event_number,
  output logic [6:0]  event_value,
  output logic [13:0] event_wide,
  output logic [63:0] notes_low,
  output logic [63:0] notes_high,
  output logic [34:0] knob_values,
  output logic [4:0]  clock_phase,
  output logic [6:0]  program_number
);

  localparam int unsigned CW = $clog2(CLOCKS_PER_BEAT);

  logic [127:0]            note_map;
  logic [6:0]              knob_store [KNOB_COUNT];
  logic [CW-1:0]           clock_count;
  logic [6:0]              program_store;
  event_t                  held;
  logic [7*KNOB_COUNT-1:0] knob_packed;

  // Take the head event whenever the output register is free or draining.
  assign pop = head_valid && (!out_valid || !out_stall);

  // Output beat: event fields are held, state fields show the live state,
  // which only moves when a new beat is loaded.
  assign event_kind     = held.kind;
  assign event_channel  = held.chan;
  assign event_number   = held.num;
  assign event_value    = held.val;
  assign event_wide     = held.wide;
  assign notes_low      = note_map[63:0];
  assign notes_high     = note_map[127:64];
  assign knob_values    = 35'(knob_packed);
  assign clock_phase    = 5'(clock_count);
  assign program_number = program_store;

  // Pack the knob values, lowest controller in the lowest bits.
  always_comb begin
    for (int i = 0; i < KNOB_COUNT; i++) begin
      knob_packed[7*i +: 7] = knob_store[i];
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Event payload register.
  always_ff @(posedge clk) begin
    if (pop) begin
      held <= head_event;
    end
  end

  // Apply the event to the performance state.
  always_ff @(posedge clk) begin
    if (rst) begin
      note_map      <= '0;
      clock_count   <= '0;
      program_store <= 7'd0;
      for (int i = 0; i < KNOB_COUNT; i++) begin
        knob_store[i] <= 7'd0;
      end
    end else if (pop) begin
      case (head_event.kind)
        EV_NOTE_ON:  note_map[head_event.num] <= 1'b1;
        EV_NOTE_OFF: note_map[head_event.num] <= 1'b0;
        EV_CC: begin
          for (int i = 0; i < KNOB_COUNT; i++) begin
            if (head_event.num == 7'(KNOB_FIRST + i)) begin
              knob_store[i] <= head_event.val;
            end
          end
        end
        EV_PROG: program_store <= head_event.val;
        EV_CLOCK: begin
          if (clock_count == CW'(CLOCKS_PER_BEAT - 1)) begin
            clock_count <= '0;
          end else begin
            clock_count <= clock_count + 1'b1;
          end
        end
        EV_START, EV_CONT: clock_count <= '0;
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/midi_receive_state_tracker_unit.sv
// Top level of the MIDI receive state tracker with its configuration port.
//
// Takes one received MIDI byte per beat and returns one result beat for it:
// the decoded event with its channel and data fields, plus the note map,
// the stored controller values, the clock phase and the program number as
// they stand after that byte. A new byte is accepted every clock cycle
// while the queue is not full; the parser decodes it in the cycle it is
// accepted and writes it into a two-entry queue, and the back end then
// takes it from the queue, applies it to the performance state and loads
// the output register. The queue and the output register let either side
// stall without stopping the other at once.
// listen_channel sits at byte address 0 of the APB port; write it only
// while the block is idle.
module midi_receive_state_tracker_unit
  import mrst_pkg::*;
#(
  parameter int unsigned KNOB_COUNT      = 5,
  parameter int unsigned CLOCKS_PER_BEAT = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  event_kind,
  output logic [4:0]  event_channel,
  output logic [6:0]  event_number,
  output logic [6:0]  event_value,
  output logic [13:0] event_wide,
  output logic [63:0] notes_low,
  output logic [63:0] notes_high,
  output logic [34:0] knob_values,
  output logic [4:0]  clock_phase,
  output logic [6:0]  program_number
);

  logic       listen_sel;
  logic [4:0] listen_channel;
  logic       push;
  event_t     push_event;
  logic       q_full;
  logic       pop;
  logic       head_valid;
  event_t     head_event;

  // Configuration register.
  assign pready     = 1'b1;
  assign listen_sel = (paddr[2] == ADDR_LISTEN[2]);
  assign prdata     = listen_sel ? {27'd0, listen_channel} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      listen_channel <= 5'd0;
    end else if (psel && penable && pwrite && pready && listen_sel) begin
      listen_channel <= pwdata[4:0];
    end
  end

  // Input stalls only when the queue is full.
  assign in_stall = q_full;

  mrst_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (rx_byte),
    .listen_channel (listen_channel),
    .push           (push),
    .push_event     (push_event)
  );

  mrst_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_event (push_event),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_event (head_event)
  );

  mrst_back #(
    .KNOB_COUNT      (KNOB_COUNT),
    .CLOCKS_PER_BEAT (CLOCKS_PER_BEAT)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_event     (head_event),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .event_kind     (event_kind),
    .event_channel  (event_channel),
    .event_number   (event_number),
    .event_value    (event_value),
    .event_wide     (event_wide),
    .notes_low      (notes_low),
    .notes_high     (notes_high),
    .knob_values    (knob_values),
    .clock_phase    (clock_phase),
    .program_number (program_number)
  );

endmodule
